// ===== rtl/residual_stats_welford_unit_defines.svh =====
// Assertion helpers shared by the residual statistics unit.
// Each use expands to one labeled concurrent assertion on aclk.
`ifndef RESIDUAL_STATS_WELFORD_UNIT_DEFINES_SVH
`define RESIDUAL_STATS_WELFORD_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RSW_ASSERT_IMPL(name, cond, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("rsw: assertion failed");

// Next-cycle implication.
`define RSW_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("rsw: assertion failed");

`endif

// ===== rtl/rsw_pkg.sv =====
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and constants of the residual statistics unit.
// ----------------------------------------------------------------------------
package rsw_pkg;

    localparam int DEF_MAX_BINS = 65536;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_STEPS    = 64;
    localparam int ROOT_STEPS   = 32;

    typedef struct packed {
        logic signed [31:0] residual;
        logic [31:0]        error_a;
        logic [31:0]        error_u;
        logic [31:0]        error_s;
        logic [31:0]        count;
        logic               used;
        logic               last;
    } rsw_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL,
        ST_M2,
        ST_SQ,
        ST_ROOT_ERR,
        ST_CHECK,
        ST_DIV_VAR,
        ST_ROOT_SIG,
        ST_FIN
    } rsw_state_t;

endpackage

// ===== rtl/rsw_front.sv =====
// ----------------------------------------------------------------------------
// rsw_front
// Accepts input beats, forms the saturated residual and classifies the bin.
// ----------------------------------------------------------------------------
module rsw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_energy_a,
    input  logic signed [31:0] s_energy_u,
    input  logic signed [31:0] s_energy_s,
    input  logic [31:0]        s_error_a,
    input  logic [31:0]        s_error_u,
    input  logic [31:0]        s_error_s,
    input  logic [31:0]        s_sample_count,
    input  logic               s_last_bin,
    output logic               push_valid,
    input  logic               push_ready,
    output rsw_pkg::rsw_item_t push_item
);
    import rsw_pkg::*;

    logic               hold_valid_reg;
    rsw_item_t          hold_item_reg;
    rsw_item_t          item_next;
    logic signed [33:0] diff;
    logic signed [31:0] sat;
    logic               used;

    assign s_ready    = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_comb begin
        diff = 34'(s_energy_a) - (34'(s_energy_u) + 34'(s_energy_s));
        if (diff > 34'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (diff < -34'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = diff[31:0];
        end
        used                = (s_sample_count != 32'd0);
        item_next.residual  = used ? sat : 32'sd0;
        item_next.error_a   = s_error_a;
        item_next.error_u   = s_error_u;
        item_next.error_s   = s_error_s;
        item_next.count     = s_sample_count;
        item_next.used      = used;
        item_next.last      = s_last_bin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            hold_item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/rsw_queue.sv =====
// ----------------------------------------------------------------------------
// rsw_queue
// Short queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "residual_stats_welford_unit_defines.svh"

module rsw_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  rsw_pkg::rsw_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rsw_pkg::rsw_item_t pop_item
);
    import rsw_pkg::*;

    rsw_item_t  entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `RSW_ASSERT_IMPL(a_q_bound, 1'b1, count_reg <= 2'(QUEUE_DEPTH))
    `RSW_ASSERT_NEXT(a_q_push_count, do_push && !do_pop, count_reg == $past(count_reg) + 2'd1)
    `RSW_ASSERT_NEXT(a_q_pop_count, do_pop && !do_push, count_reg == $past(count_reg) - 2'd1)

endmodule

// ===== rtl/rsw_back.sv =====
// ----------------------------------------------------------------------------
// rsw_back
// Sequencer for the Welford update, error root and end-of-surface summary.
// ----------------------------------------------------------------------------
`include "residual_stats_welford_unit_defines.svh"

module rsw_back #(
    parameter int MAX_BINS = rsw_pkg::DEF_MAX_BINS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               include_error,
    input  logic               q_valid,
    output logic               q_pop,
    input  rsw_pkg::rsw_item_t q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_residual,
    output logic [31:0]        m_residual_error,
    output logic               m_bin_used,
    output logic [31:0]        m_count_out,
    output logic signed [31:0] m_mean_out,
    output logic [31:0]        m_max_abs_out,
    output logic [31:0]        m_sigma_out,
    output logic               m_summary_valid
);
    import rsw_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS + 1);

    rsw_state_t         state_reg;
    rsw_state_t         state_next;
    rsw_item_t          item_reg;

    logic [CNT_W-1:0]   used_count_reg;
    logic signed [47:0] mean_reg;
    logic [63:0]        m2_reg;
    logic [31:0]        max_abs_reg;

    logic               dx_neg_reg;
    logic [49:0]        mag1_reg;
    logic [49:0]        mag2_reg;

    logic [63:0]        dvd_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   divisor_reg;
    logic [5:0]         step_reg;

    logic [2:0]         mstep_reg;
    logic [63:0]        pp_reg;
    logic [99:0]        acc_reg;
    logic [65:0]        sq_acc_reg;

    logic [63:0]        v_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;

    logic [31:0]        err_reg;

    logic               m_valid_reg;
    logic signed [31:0] res_out_reg;
    logic [31:0]        err_out_reg;
    logic               used_out_reg;
    logic [31:0]        count_out_reg;
    logic signed [31:0] mean_out_reg;
    logic [31:0]        max_out_reg;
    logic [31:0]        sigma_out_reg;
    logic               summary_out_reg;

    logic               fin_go;

    // Datapath combinational terms
    logic signed [49:0] res48;
    logic signed [49:0] dx1;
    logic [49:0]        mag1;
    logic [31:0]        mag_res;
    logic [CNT_W-1:0]   cnt_new;
    logic [CNT_W:0]     trial;
    logic               div_ge;
    logic [CNT_W-1:0]   rem_next;
    logic [63:0]        dvd_next;
    logic [49:0]        quot;
    logic signed [49:0] qs;
    logic signed [47:0] mean_new;
    logic signed [49:0] dx2;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [6:0]         acc_sh;
    logic [67:0]        prod_hi;
    logic [63:0]        p_sat;
    logic [64:0]        m2_sum;
    logic [63:0]        root_trial;
    logic               root_ge;
    logic signed [47:0] mq_raw;
    logic signed [47:0] mq;

    always_comb begin
        res48    = 50'(signed'({item_reg.residual, 16'h0000}));
        dx1      = res48 - 50'(mean_reg);
        mag1     = dx1[49] ? 50'(-dx1) : 50'(dx1);
        mag_res  = item_reg.residual[31] ? 32'(-item_reg.residual) : 32'(item_reg.residual);
        cnt_new  = (used_count_reg < CNT_W'(MAX_BINS)) ? used_count_reg + 1'b1
                                                        : used_count_reg;

        // One restoring division step
        trial    = {rem_reg, dvd_reg[63]};
        div_ge   = (trial >= {1'b0, divisor_reg});
        rem_next = div_ge ? CNT_W'(trial - {1'b0, divisor_reg}) : CNT_W'(trial);
        dvd_next = {dvd_reg[62:0], div_ge};

        quot     = dvd_reg[49:0];
        qs       = dx_neg_reg ? -signed'(quot) : signed'(quot);
        mean_new = mean_reg + qs[47:0];
        dx2      = res48 - 50'(mean_new);

        // Operands: low/high magnitude halves; error terms in ST_SQ
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == ST_SQ) begin
            case (mstep_reg)
                3'd0:    begin mul_a = item_reg.error_a; mul_b = item_reg.error_a; end
                3'd1:    begin mul_a = item_reg.error_u; mul_b = item_reg.error_u; end
                3'd2:    begin mul_a = item_reg.error_s; mul_b = item_reg.error_s; end
                default: begin mul_a = 32'd0; mul_b = 32'd0; end
            endcase
        end else begin
            case (mstep_reg)
                3'd0:    begin mul_a = mag1_reg[31:0]; mul_b = mag2_reg[31:0]; end
                3'd1:    begin mul_a = mag1_reg[31:0]; mul_b = 32'(mag2_reg[49:32]); end
                3'd2:    begin mul_a = 32'(mag1_reg[49:32]); mul_b = mag2_reg[31:0]; end
                3'd3:    begin mul_a = 32'(mag1_reg[49:32]); mul_b = 32'(mag2_reg[49:32]); end
                default: begin mul_a = 32'd0; mul_b = 32'd0; end
            endcase
        end
        case (mstep_reg)
            3'd1:    acc_sh = 7'd0;
            3'd4:    acc_sh = 7'd64;
            default: acc_sh = 7'd32;
        endcase

        prod_hi = acc_reg[99:32];
        p_sat   = (prod_hi[67:64] != 4'd0) ? {64{1'b1}} : prod_hi[63:0];
        m2_sum  = {1'b0, m2_reg} + {1'b0, p_sat};

        // One step of the bitwise integer root
        root_trial = r_reg + bit_reg;
        root_ge    = (v_reg >= root_trial);

        // Mean from Q31.16 to an integer, truncated toward zero
        mq_raw = mean_reg >>> 16;
        mq     = (mean_reg[47] && (mean_reg[15:0] != 16'd0)) ? mq_raw + 48'sd1 : mq_raw;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_item.used ? ST_UPD : ST_CHECK;
                end
            end
            ST_UPD:      state_next = ST_DIV_MEAN;
            ST_DIV_MEAN: begin
                if (step_reg == 6'd0) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:     state_next = ST_MUL;
            ST_MUL: begin
                if (mstep_reg == 3'd4) begin
                    state_next = ST_M2;
                end
            end
            ST_M2:       state_next = include_error ? ST_SQ : ST_CHECK;
            ST_SQ: begin
                if (mstep_reg == 3'd4) begin
                    state_next = (sq_acc_reg[65:64] != 2'd0) ? ST_CHECK : ST_ROOT_ERR;
                end
            end
            ST_ROOT_ERR: begin
                if (step_reg == 6'd0) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (item_reg.last && (used_count_reg != '0)) begin
                    state_next = ST_DIV_VAR;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV_VAR: begin
                if (step_reg == 6'd0) begin
                    state_next = ST_ROOT_SIG;
                end
            end
            ST_ROOT_SIG: begin
                if (step_reg == 6'd0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        q_pop  = (state_reg == ST_IDLE) && q_valid;
        fin_go = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            mean_reg       <= '0;
            m2_reg         <= '0;
            max_abs_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_UPD: begin
                    if (mag_res > max_abs_reg) begin
                        max_abs_reg <= mag_res;
                    end
                    used_count_reg <= cnt_new;
                end
                ST_MEAN: begin
                    mean_reg <= mean_new;
                end
                ST_M2: begin
                    m2_reg <= m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
                end
                ST_FIN: begin
                    // Drop the statistics once the summary is out
                    if (fin_go && item_reg.last) begin
                        used_count_reg <= '0;
                        mean_reg       <= '0;
                        m2_reg         <= '0;
                        max_abs_reg    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_reg <= q_item;
                end
                err_reg <= 32'd0;
            end
            ST_UPD: begin
                dx_neg_reg  <= dx1[49];
                mag1_reg    <= mag1;
                dvd_reg     <= 64'(mag1);
                rem_reg     <= '0;
                divisor_reg <= cnt_new;
                step_reg    <= 6'(DIV_STEPS - 1);
            end
            ST_DIV_MEAN, ST_DIV_VAR: begin
                dvd_reg  <= dvd_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - 6'd1;
                if (step_reg == 6'd0) begin
                    v_reg    <= dvd_next;
                    r_reg    <= 64'd0;
                    bit_reg  <= 64'd1 << 62;
                    step_reg <= 6'(ROOT_STEPS - 1);
                end
            end
            ST_MEAN: begin
                mag2_reg  <= dx2[49] ? 50'(-dx2) : 50'(dx2);
                mstep_reg <= 3'd0;
                acc_reg   <= '0;
            end
            ST_MUL: begin
                pp_reg    <= 64'(mul_a) * 64'(mul_b);
                mstep_reg <= mstep_reg + 3'd1;
                if (mstep_reg != 3'd0) begin
                    acc_reg <= acc_reg + (100'(pp_reg) << acc_sh);
                end
            end
            ST_M2: begin
                mstep_reg  <= 3'd0;
                sq_acc_reg <= '0;
            end
            ST_SQ: begin
                pp_reg    <= 64'(mul_a) * 64'(mul_b);
                mstep_reg <= mstep_reg + 3'd1;
                if (mstep_reg != 3'd0 && mstep_reg != 3'd4) begin
                    sq_acc_reg <= sq_acc_reg + 66'(pp_reg);
                end
                if (mstep_reg == 3'd4) begin
                    err_reg  <= {32{1'b1}};
                    v_reg    <= sq_acc_reg[63:0];
                    r_reg    <= 64'd0;
                    bit_reg  <= 64'd1 << 62;
                    step_reg <= 6'(ROOT_STEPS - 1);
                end
            end
            ST_ROOT_ERR, ST_ROOT_SIG: begin
                if (root_ge) begin
                    v_reg <= v_reg - root_trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg - 6'd1;
                if (state_reg == ST_ROOT_ERR && step_reg == 6'd0) begin
                    err_reg <= root_ge ? 32'((r_reg >> 1) + bit_reg) : 32'(r_reg >> 1);
                end
            end
            ST_CHECK: begin
                dvd_reg     <= m2_reg;
                rem_reg     <= '0;
                divisor_reg <= used_count_reg;
                step_reg    <= 6'(DIV_STEPS - 1);
            end
            ST_FIN: begin
                if (fin_go) begin
                    res_out_reg     <= item_reg.residual;
                    err_out_reg     <= (item_reg.used && include_error) ? err_reg : 32'd0;
                    used_out_reg    <= item_reg.used;
                    count_out_reg   <= item_reg.used ? item_reg.count : 32'd0;
                    summary_out_reg <= item_reg.last;
                    if (item_reg.last && (used_count_reg != '0)) begin
                        mean_out_reg  <= mq[31:0];
                        max_out_reg   <= max_abs_reg;
                        sigma_out_reg <= r_reg[31:0];
                    end else begin
                        mean_out_reg  <= 32'sd0;
                        max_out_reg   <= 32'd0;
                        sigma_out_reg <= 32'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_residual       = res_out_reg;
    assign m_residual_error = err_out_reg;
    assign m_bin_used       = used_out_reg;
    assign m_count_out      = count_out_reg;
    assign m_mean_out       = mean_out_reg;
    assign m_max_abs_out    = max_out_reg;
    assign m_sigma_out      = sigma_out_reg;
    assign m_summary_valid  = summary_out_reg;

    `RSW_ASSERT_IMPL(a_count_cap, 1'b1, used_count_reg <= CNT_W'(MAX_BINS))
    `RSW_ASSERT_IMPL(a_pop_idle, q_pop, state_reg == ST_IDLE)
    `RSW_ASSERT_NEXT(a_last_clears, fin_go && item_reg.last, used_count_reg == '0 && m2_reg == '0)

endmodule

// ===== rtl/residual_stats_welford_unit.sv =====
// The back end takes one bin at a time and pops no new bin until the previous one
// has gone to the output register; an unused bin skips the arithmetic, include_error
// adds the error root, and a last bin with used bins adds the variance division and
// root. The pace is set by the 64-step radix-2 divider and the 32-step bitwise root unit.
// Reset (aresetn low, synchronous) clears statistics, queue and include_error.
// ----------------------------------------------------------------------------
// residual_stats_welford_unit
// Per-bin residual with running Welford mean, M2, max and error root.
// ----------------------------------------------------------------------------
module residual_stats_welford_unit #(
    parameter int MAX_BINS = rsw_pkg::DEF_MAX_BINS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_energy_a,
    input  logic signed [31:0] s_energy_u,
    input  logic signed [31:0] s_energy_s,
    input  logic [31:0]        s_error_a,
    input  logic [31:0]        s_error_u,
    input  logic [31:0]        s_error_s,
    input  logic [31:0]        s_sample_count,
    input  logic               s_last_bin,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_residual,
    output logic [31:0]        m_residual_error,
    output logic               m_bin_used,
    output logic [31:0]        m_count_out,
    output logic signed [31:0] m_mean_out,
    output logic [31:0]        m_max_abs_out,
    output logic [31:0]        m_sigma_out,
    output logic               m_summary_valid
);
    import rsw_pkg::*;

    logic      include_error_reg;
    logic      push_valid;
    logic      push_ready;
    rsw_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    rsw_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_error_reg <= 1'b0;
        end else if (cfg_valid) begin
            include_error_reg <= cfg_data;
        end
    end

    rsw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_energy_a     (s_energy_a),
        .s_energy_u     (s_energy_u),
        .s_energy_s     (s_energy_s),
        .s_error_a      (s_error_a),
        .s_error_u      (s_error_u),
        .s_error_s      (s_error_s),
        .s_sample_count (s_sample_count),
        .s_last_bin     (s_last_bin),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    rsw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rsw_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .include_error    (include_error_reg),
        .q_valid          (pop_valid),
        .q_pop            (pop_ready),
        .q_item           (pop_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_residual       (m_residual),
        .m_residual_error (m_residual_error),
        .m_bin_used       (m_bin_used),
        .m_count_out      (m_count_out),
        .m_mean_out       (m_mean_out),
        .m_max_abs_out    (m_max_abs_out),
        .m_sigma_out      (m_sigma_out),
        .m_summary_valid  (m_summary_valid)
    );

endmodule

// ===== test/residual_stats_welford_unit_tb.sv =====
// ----------------------------------------------------------------------------
// residual_stats_welford_unit_tb
// Self-checking bench for the residual statistics unit. A driver feeds bins
// from a queue, a predictor folds each accepted bin into its own Welford
// statistics, and a monitor checks every result beat against the oldest
// prediction. Both handshakes stall in random bursts, and the run covers
// both settings of include_error.
// ----------------------------------------------------------------------------
module residual_stats_welford_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Bin limit of the block.
    localparam int           TB_MAX_BINS = 65536;
    localparam longint       RUN_LIMIT   = 3000000;
    localparam logic [31:0]  ALL_ONES    = 32'hFFFF_FFFF;

    typedef struct {
        logic signed [31:0] energy_a;
        logic signed [31:0] energy_u;
        logic signed [31:0] energy_s;
        logic [31:0]        error_a;
        logic [31:0]        error_u;
        logic [31:0]        error_s;
        logic [31:0]        sample_count;
        logic               last_bin;
    } bin_item_t;

    typedef struct packed {
        logic signed [31:0] residual;
        logic [31:0]        residual_error;
        logic               bin_used;
        logic [31:0]        count_out;
        logic signed [31:0] mean_out;
        logic [31:0]        max_abs_out;
        logic [31:0]        sigma_out;
        logic               summary_valid;
    } bin_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_energy_a = '0;
    logic signed [31:0] s_energy_u = '0;
    logic signed [31:0] s_energy_s = '0;
    logic [31:0]        s_error_a = '0;
    logic [31:0]        s_error_u = '0;
    logic [31:0]        s_error_s = '0;
    logic [31:0]        s_sample_count = '0;
    logic               s_last_bin = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_residual;
    logic [31:0]        m_residual_error;
    logic               m_bin_used;
    logic [31:0]        m_count_out;
    logic signed [31:0] m_mean_out;
    logic [31:0]        m_max_abs_out;
    logic [31:0]        m_sigma_out;
    logic               m_summary_valid;

    bin_item_t   pending_bins[$];
    bin_result_t expected_results[$];
    int          mismatches = 0;
    bit          quiet = 0;
    longint      cycles = 0;

    // predictor state
    logic              err_enable = 1'b0;
    longint unsigned   bins_seen = 0;
    longint            mean_acc = 0;
    logic [63:0]       m2_acc = '0;
    logic [31:0]       peak_abs = '0;

    residual_stats_welford_unit #(
        .MAX_BINS(TB_MAX_BINS)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_energy_a(s_energy_a), .s_energy_u(s_energy_u), .s_energy_s(s_energy_s),
        .s_error_a(s_error_a), .s_error_u(s_error_u), .s_error_s(s_error_s),
        .s_sample_count(s_sample_count), .s_last_bin(s_last_bin),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_residual(m_residual), .m_residual_error(m_residual_error),
        .m_bin_used(m_bin_used), .m_count_out(m_count_out),
        .m_mean_out(m_mean_out), .m_max_abs_out(m_max_abs_out),
        .m_sigma_out(m_sigma_out), .m_summary_valid(m_summary_valid)
    );

    always #6 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] error_root(logic [31:0] ea, logic [31:0] eu,
                                               logic [31:0] es);
        logic [64:0] t;
        logic [64:0] u;
        t = {1'b0, 64'(ea) * 64'(ea)} + {1'b0, 64'(eu) * 64'(eu)};
        if (t[64]) return ALL_ONES;
        u = {1'b0, t[63:0]} + {1'b0, 64'(es) * 64'(es)};
        if (u[64]) return ALL_ONES;
        return 32'(int_sqrt(u[63:0]));
    endfunction

    // Fold one accepted bin into the running statistics.
    function automatic bin_result_t fold_bin(bin_item_t it);
        bin_result_t r;
        longint      res;
        longint      res48;
        longint      dx1;
        longint      dx2;
        logic [63:0] mag1;
        logic [63:0] mag2;
        logic [127:0] prod;
        logic [64:0] sum;
        r = '0;
        if (it.sample_count != 0) begin
            res = longint'(it.energy_a) - (longint'(it.energy_u) + longint'(it.energy_s));
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            if ((res < 0 ? -res : res) > longint'({32'd0, peak_abs}))
                peak_abs = 32'(res < 0 ? -res : res);
            if (bins_seen < TB_MAX_BINS) bins_seen++;
            res48 = res * 65536;
            dx1 = res48 - mean_acc;
            mean_acc = mean_acc + dx1 / longint'(bins_seen);
            dx2 = res48 - mean_acc;
            mag1 = dx1 < 0 ? -dx1 : dx1;
            mag2 = dx2 < 0 ? -dx2 : dx2;
            prod = (128'(mag1) * 128'(mag2)) >> 32;
            if (prod[127:64] != 0) prod[63:0] = '1;
            sum = {1'b0, m2_acc} + {1'b0, prod[63:0]};
            m2_acc = sum[64] ? '1 : sum[63:0];
            r.residual = 32'(res);
            if (err_enable) r.residual_error = error_root(it.error_a, it.error_u, it.error_s);
            r.bin_used = 1'b1;
            r.count_out = it.sample_count;
        end
        if (it.last_bin) begin
            if (bins_seen != 0) begin
                r.mean_out = 32'(mean_acc / 65536);
                r.max_abs_out = peak_abs;
                r.sigma_out = 32'(int_sqrt(m2_acc / bins_seen));
            end
            r.summary_valid = 1'b1;
            bins_seen = 0;
            mean_acc = 0;
            m2_acc = '0;
            peak_abs = '0;
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin : bin_driver
        bin_item_t it;
        int        hold_off;
        if (!aresetn) begin
            s_valid <= 1'b0;
            hold_off = 0;
        end else begin
            if (s_valid && s_ready) begin
                it.energy_a = s_energy_a; it.energy_u = s_energy_u;
                it.energy_s = s_energy_s; it.error_a = s_error_a;
                it.error_u = s_error_u; it.error_s = s_error_s;
                it.sample_count = s_sample_count; it.last_bin = s_last_bin;
                expected_results.push_back(fold_bin(it));
            end
            if (!(s_valid && !s_ready)) begin
                if (hold_off > 0) begin
                    hold_off--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    hold_off = $urandom_range(1, 18) - 1;
                    s_valid <= 1'b0;
                end else if (pending_bins.size() > 0) begin
                    it = pending_bins.pop_front();
                    s_energy_a <= it.energy_a; s_energy_u <= it.energy_u;
                    s_energy_s <= it.energy_s; s_error_a <= it.error_a;
                    s_error_u <= it.error_u; s_error_s <= it.error_s;
                    s_sample_count <= it.sample_count; s_last_bin <= it.last_bin;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : result_monitor
        bin_result_t got;
        bin_result_t want;
        int          stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_residual, m_residual_error, m_bin_used, m_count_out,
                       m_mean_out, m_max_abs_out, m_sigma_out, m_summary_valid};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: res=%h err=%h used=%b cnt=%h",
                                 got.residual, got.residual_error, got.bin_used,
                                 got.count_out);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp res=%h err=%h used=%b cnt=%h mean=%h ",
                                      "max=%h sig=%h sv=%b / got res=%h err=%h used=%b ",
                                      "cnt=%h mean=%h max=%h sig=%h sv=%b"},
                                     want.residual, want.residual_error, want.bin_used,
                                     want.count_out, want.mean_out, want.max_abs_out,
                                     want.sigma_out, want.summary_valid,
                                     got.residual, got.residual_error, got.bin_used,
                                     got.count_out, got.mean_out, got.max_abs_out,
                                     got.sigma_out, got.summary_valid);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("residual_stats_welford_unit regression: fail");
            $finish;
        end
    end

    task automatic push_bin(logic [31:0] a, logic [31:0] u, logic [31:0] s,
                            logic [31:0] ea, logic [31:0] eu, logic [31:0] es,
                            logic [31:0] cnt, logic last);
        bin_item_t it;
        it.energy_a = a; it.energy_u = u; it.energy_s = s;
        it.error_a = ea; it.error_u = eu; it.error_s = es;
        it.sample_count = cnt; it.last_bin = last;
        pending_bins.push_back(it);
    endtask

    task automatic write_cfg(logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        err_enable = v;
    endtask

    // Wait until every beat is back, then let the back end settle.
    task automatic drain();
        do @(posedge aclk);
        while (pending_bins.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'(-$urandom_range(0, 1 << 22));
            default: return 32'($urandom_range(0, 1 << 22)) - (32'd1 << 21);
        endcase
    endfunction

    function automatic logic [31:0] rand_error();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ALL_ONES - $urandom_range(0, 3);
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    task automatic random_surfaces(int target);
        int made;
        int len;
        logic [31:0] cnt;
        made = 0;
        while (made < target) begin
            // some surfaces run longer
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0: cnt = 0;
                    1: cnt = $urandom;
                    default: cnt = $urandom_range(1, 1000);
                endcase
                push_bin(rand_energy(), rand_energy(), rand_energy(),
                         rand_error(), rand_error(), rand_error(), cnt, i == len - 1);
            end
            made += len;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_cfg(1'b1);
        // last bin with no used bins, then unused last bin after used ones
        push_bin(32'd5, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 1'b1);
        push_bin(32'h0001_0000, 32'd0, 32'd0, 32'd3, 32'd4, 32'd0, 32'd1, 1'b0);
        push_bin(32'h0003_0000, 32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd7, 1'b0);
        push_bin(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        // positive and negative saturation of the residual
        push_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, ALL_ONES, ALL_ONES,
                 ALL_ONES, ALL_ONES, 1'b0);
        push_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ALL_ONES, ALL_ONES,
                 32'd0, 32'd1, 1'b0);
        push_bin(32'h8000_0000, 32'd0, 32'd0, ALL_ONES, 32'd0, 32'd0, 32'd2, 1'b0);
        push_bin(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, ALL_ONES, 32'd3, 1'b1);
        // one longer surface with a ramp of residuals
        for (int i = 0; i < 20; i++)
            push_bin(32'(i * 32'h0001_3000), 32'h0000_4000, 32'hFFFF_0000,
                     32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'(i + 1), i == 19);
        drain();

        write_cfg(1'b0);
        random_surfaces(600);
        drain();

        write_cfg(1'b1);
        random_surfaces(700);
        drain();

        quiet = 1;
        write_cfg(1'b0);
        write_cfg(1'b1);
        random_surfaces(620);
        drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("residual_stats_welford_unit regression: pass");
        end else begin
            $display("residual_stats_welford_unit regression: fail");
        end
        $finish;
    end

endmodule
